### hw/rtl/rds_pkg.sv
// Shared types and constants for the recipe dosing sequencer.
// Used by every module under hw/rtl; no dependencies of its own.
`default_nettype none

package rds_pkg;

    // Store and recipe geometry
    localparam int SLOTS      = 5;
    localparam int COMPONENTS = 6;
    localparam int DOSE_BITS  = 8;
    localparam int SLOT_W     = 3;
    localparam int COMP_W     = 3;
    localparam int RATE_W     = 10;
    localparam int PRE_W      = 12;
    localparam int TICK_W     = 16;
    // A dose times a rate always fits, so the pump count needs no saturation
    localparam int PHASE_W    = DOSE_BITS + RATE_W;

    // Dosing phase codes
    localparam int             PHASE_CODE_W = 2;
    localparam logic [1:0]     PH_IDLE      = 2'd0;
    localparam logic [1:0]     PH_PRE       = 2'd1;
    localparam logic [1:0]     PH_PUMP      = 2'd2;
    localparam logic [1:0]     PH_POST      = 2'd3;

    // Configuration register indexes
    localparam int             CFG_IDX_W       = 3;
    localparam int             CFG_DATA_W      = 16;
    localparam logic [2:0]     CFG_LONG_PRESS  = 3'd0;
    localparam logic [2:0]     CFG_LIQUID_RATE = 3'd1;
    localparam logic [2:0]     CFG_GAS_RATE    = 3'd2;
    localparam logic [2:0]     CFG_PRE_PUMP    = 3'd3;
    localparam logic [2:0]     CFG_POST_DOSE   = 3'd4;
    localparam logic [2:0]     CFG_RELAY_ON    = 3'd5;
    localparam logic [2:0]     CFG_RELAY_CYCLE = 3'd6;

    // Configuration reset values
    localparam logic [TICK_W-1:0] RST_LONG_PRESS  = 16'd2000;
    localparam logic [RATE_W-1:0] RST_LIQUID_RATE = 10'd172;
    localparam logic [RATE_W-1:0] RST_GAS_RATE    = 10'd50;
    localparam logic [PRE_W-1:0]  RST_PRE_PUMP    = 12'd200;
    localparam logic [PRE_W-1:0]  RST_POST_DOSE   = 12'd500;
    localparam logic [TICK_W-1:0] RST_RELAY_ON    = 16'd500;
    localparam logic [TICK_W-1:0] RST_RELAY_CYCLE = 16'd15500;

    typedef struct packed {
        logic [COMPONENTS-1:0]                gas_mask;
        logic [COMPONENTS-1:0][DOSE_BITS-1:0] dose;
    } recipe_t;

    typedef struct packed {
        logic [TICK_W-1:0] long_press;
        logic [RATE_W-1:0] liquid_rate;
        logic [RATE_W-1:0] gas_rate;
        logic [PRE_W-1:0]  pre_pump;
        logic [PRE_W-1:0]  post_dose;
        logic [TICK_W-1:0] relay_on;
        logic [TICK_W-1:0] relay_cycle;
    } cfg_t;

    typedef struct packed {
        logic [COMPONENTS-1:0] valve_mask;
        logic                  pump_liquid;
        logic                  pump_gas;
        logic                  bypass_valve;
        logic [SLOT_W-1:0]     selected_slot;
        logic                  busy_res;
        logic [COMP_W-1:0]     active_component;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/rds_cfg.sv
// Configuration register file of the recipe dosing sequencer.
// Depends on rds_pkg for register indexes, widths and reset values.
`default_nettype none

module rds_cfg
    import rds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_idx,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    // Write one register per transfer; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press  <= RST_LONG_PRESS;
            cfg_reg.liquid_rate <= RST_LIQUID_RATE;
            cfg_reg.gas_rate    <= RST_GAS_RATE;
            cfg_reg.pre_pump    <= RST_PRE_PUMP;
            cfg_reg.post_dose   <= RST_POST_DOSE;
            cfg_reg.relay_on    <= RST_RELAY_ON;
            cfg_reg.relay_cycle <= RST_RELAY_CYCLE;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                CFG_LONG_PRESS:  cfg_reg.long_press  <= wr_data[TICK_W-1:0];
                CFG_LIQUID_RATE: cfg_reg.liquid_rate <= wr_data[RATE_W-1:0];
                CFG_GAS_RATE:    cfg_reg.gas_rate    <= wr_data[RATE_W-1:0];
                CFG_PRE_PUMP:    cfg_reg.pre_pump    <= wr_data[PRE_W-1:0];
                CFG_POST_DOSE:   cfg_reg.post_dose   <= wr_data[PRE_W-1:0];
                CFG_RELAY_ON:    cfg_reg.relay_on    <= wr_data[TICK_W-1:0];
                CFG_RELAY_CYCLE: cfg_reg.relay_cycle <= wr_data[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/rds_store.sv
// Recipe store: a shift line of recipes, newest in slot 0, read at one slot.
// Depends on rds_pkg for recipe_t and the slot count.
`default_nettype none

module rds_store
    import rds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_en,
    input  wire recipe_t           load_recipe,
    input  wire logic [SLOT_W-1:0] rd_slot,
    output recipe_t                rd_recipe
);

    recipe_t slot_reg [SLOTS];

    // Push the new recipe in at slot 0 and drop the oldest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (load_en)
        begin
            slot_reg[0] <= load_recipe;
            for (int i = 1; i < SLOTS; i++)
            begin
                slot_reg[i] <= slot_reg[i-1];
            end
        end
    end

    // Read the selected slot; an index past the end falls back to slot 0
    assign rd_recipe = (rd_slot < SLOT_W'(SLOTS)) ? slot_reg[rd_slot] : slot_reg[0];

endmodule

`default_nettype wire

### hw/rtl/rds_seq.sv
// Button handling, keep-alive timer and dosing phase sequencer.
// Depends on rds_pkg; reads the selected recipe from rds_store.
`default_nettype none

module rds_seq
    import rds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              action,
    input  wire logic              button_down,
    input  wire cfg_t              cfg,
    input  wire recipe_t           sel_recipe,
    output logic [SLOT_W-1:0]      sel_slot,
    output result_t                result
);

    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    held_reg, held_next;
    logic                    toggled_reg, toggled_next;
    logic [TICK_W-1:0]       hold_reg, hold_next;
    logic [TICK_W-1:0]       relay_reg, relay_next;
    logic [PHASE_CODE_W-1:0] phase_reg, phase_next;
    logic [COMP_W-1:0]       comp_reg, comp_next;
    logic [PHASE_W-1:0]      timer_reg, timer_next;
    recipe_t                 latch_reg, latch_next;
    logic                    gas_reg, gas_next;

    logic [TICK_W-1:0]       relay_inc;
    logic [TICK_W-1:0]       hold_inc;
    logic [COMP_W:0]         first_hit;
    logic [COMP_W:0]         next_hit;
    logic [RATE_W-1:0]       rate;
    logic [PHASE_W-1:0]      pump_cnt;
    logic                    busy;

    // Lowest component at or after the start index with a nonzero dose
    function automatic logic [COMP_W:0] find_comp(recipe_t r, logic [COMP_W:0] from);
        logic [COMP_W:0] hit;
        hit = (COMP_W+1)'(COMPONENTS);
        for (int c = COMPONENTS - 1; c >= 0; c--)
        begin
            if (r.dose[c] != '0 && (COMP_W+1)'(c) >= from)
            begin
                hit = (COMP_W+1)'(c);
            end
        end
        return hit;
    endfunction

    assign relay_inc = (relay_reg != '1) ? relay_reg + TICK_W'(1) : relay_reg;
    assign hold_inc  = (hold_reg != '1) ? hold_reg + TICK_W'(1) : hold_reg;
    assign first_hit = find_comp(sel_recipe, '0);
    assign next_hit  = find_comp(latch_reg, {1'b0, comp_reg} + (COMP_W+1)'(1));
    assign rate      = gas_reg ? cfg.gas_rate : cfg.liquid_rate;
    assign pump_cnt  = PHASE_W'(latch_reg.dose[comp_reg]) * PHASE_W'(rate);

    // Next state for one item
    always_comb
    begin
        slot_next    = slot_reg;
        held_next    = held_reg;
        toggled_next = toggled_reg;
        hold_next    = hold_reg;
        relay_next   = relay_reg;
        phase_next   = phase_reg;
        comp_next    = comp_reg;
        timer_next   = timer_reg;
        latch_next   = latch_reg;
        gas_next     = gas_reg;

        if (!action)
        begin
            relay_next = relay_inc;
            if (phase_reg == PH_IDLE)
            begin
                // Restart the keep-alive cycle
                if (relay_inc >= cfg.relay_cycle)
                begin
                    relay_next = '0;
                end
                // Sample the button
                if (!held_reg && button_down)
                begin
                    held_next = 1'b1;
                    hold_next = '0;
                end
                else if (held_reg && button_down)
                begin
                    hold_next = hold_inc;
                    if (hold_inc >= cfg.long_press)
                    begin
                        toggled_next = 1'b1;
                        held_next    = 1'b0;
                        slot_next    = (slot_reg == SLOT_W'(SLOTS - 1)) ?
                                       '0 : slot_reg + SLOT_W'(1);
                    end
                end
                else if (held_reg && !button_down)
                begin
                    held_next = 1'b0;
                    if (toggled_reg)
                    begin
                        toggled_next = 1'b0;
                    end
                    else
                    begin
                        latch_next = sel_recipe;
                        if (first_hit < (COMP_W+1)'(COMPONENTS))
                        begin
                            comp_next  = first_hit[COMP_W-1:0];
                            gas_next   = sel_recipe.gas_mask[first_hit[COMP_W-1:0]];
                            phase_next = PH_PRE;
                            timer_next = PHASE_W'(cfg.pre_pump);
                        end
                    end
                end
            end
            else if (timer_reg > PHASE_W'(1))
            begin
                timer_next = timer_reg - PHASE_W'(1);
            end
            else
            begin
                // Advance to the next phase
                case (phase_reg)
                    PH_PRE:
                    begin
                        phase_next = PH_PUMP;
                        timer_next = pump_cnt;
                    end
                    PH_PUMP:
                    begin
                        phase_next = PH_POST;
                        timer_next = PHASE_W'(cfg.post_dose);
                    end
                    default:
                    begin
                        if (next_hit < (COMP_W+1)'(COMPONENTS))
                        begin
                            comp_next  = next_hit[COMP_W-1:0];
                            gas_next   = latch_reg.gas_mask[next_hit[COMP_W-1:0]];
                            phase_next = PH_PRE;
                            timer_next = PHASE_W'(cfg.pre_pump);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            comp_next  = '0;
                            gas_next   = 1'b0;
                            timer_next = '0;
                        end
                    end
                endcase
            end
        end
    end

    // Drive outputs from the state after this item
    assign busy = (phase_next != PH_IDLE);

    always_comb
    begin
        result.valve_mask       = '0;
        result.pump_liquid      = 1'b0;
        result.pump_gas         = 1'b0;
        result.bypass_valve     = relay_next < cfg.relay_on;
        result.selected_slot    = slot_next;
        result.busy_res         = busy;
        result.active_component = '0;
        if (busy)
        begin
            result.bypass_valve     = gas_next;
            result.active_component = comp_next + COMP_W'(1);
            if (phase_next != PH_POST)
            begin
                result.valve_mask = COMPONENTS'(1) << comp_next;
            end
            if (phase_next == PH_PUMP)
            begin
                result.pump_gas    = gas_next;
                result.pump_liquid = !gas_next;
            end
        end
    end

    // Commit state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            held_reg    <= 1'b0;
            toggled_reg <= 1'b0;
            hold_reg    <= '0;
            relay_reg   <= '0;
            phase_reg   <= PH_IDLE;
            comp_reg    <= '0;
            timer_reg   <= '0;
            latch_reg   <= '0;
            gas_reg     <= 1'b0;
        end
        else if (accept)
        begin
            slot_reg    <= slot_next;
            held_reg    <= held_next;
            toggled_reg <= toggled_next;
            hold_reg    <= hold_next;
            relay_reg   <= relay_next;
            phase_reg   <= phase_next;
            comp_reg    <= comp_next;
            timer_reg   <= timer_next;
            latch_reg   <= latch_next;
            gas_reg     <= gas_next;
        end
    end

    assign sel_slot = slot_reg;

endmodule

`default_nettype wire

### hw/rtl/rds_skid.sv
// Two-entry result buffer: output register plus skid stage.
// Depends on rds_pkg for result_t.
`default_nettype none

module rds_skid
    import rds_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire result_t push_data,
    output logic       push_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_data
);

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    // Control: hold a result until its transfer, refill from the skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                out_reg <= push_data;
            end
        end
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

endmodule

`default_nettype wire

### hw/rtl/recipe_dosing_sequencer_unit.sv
// Recipe dosing sequencer: pump, valve and keep-alive relay control.
// Top level; depends on rds_pkg, rds_cfg, rds_store, rds_seq and rds_skid.
//
// Input channel (in_valid/in_ready): action 0 is a tick carrying a button
// sample, action 1 loads a recipe (six doses and a gas mask) into slot 0 of
// a five-slot store. Every item yields exactly one result on the output
// channel (out_valid/out_ready) with the drives after that item.
// Config channel (cfg_valid/cfg_ready): one register per transfer, index in
// cfg_index, value in cfg_data; always ready. Write only while idle.
// Output: each result is registered, in the skid stage while one waits.
// Throughput: one item per cycle while in_ready is high; all state updates
// in one pass of logic between the state registers and the result register.
// Stall: a two-entry output buffer keeps the input ready while one result
// waits; in_ready drops only when both entries are full.
// Reset: store cleared, slot 0 selected, idle, registers at defaults; no
// clearing pass.
`default_nettype none

module recipe_dosing_sequencer_unit
    import rds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  action,
    input  wire logic                  button_down,
    input  wire logic [DOSE_BITS-1:0]  dose_one,
    input  wire logic [DOSE_BITS-1:0]  dose_two,
    input  wire logic [DOSE_BITS-1:0]  dose_three,
    input  wire logic [DOSE_BITS-1:0]  dose_four,
    input  wire logic [DOSE_BITS-1:0]  dose_five,
    input  wire logic [DOSE_BITS-1:0]  dose_six,
    input  wire logic [COMPONENTS-1:0] gas_mask,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COMPONENTS-1:0]      valve_mask,
    output logic                       pump_liquid,
    output logic                       pump_gas,
    output logic                       bypass_valve,
    output logic [SLOT_W-1:0]          selected_slot,
    output logic                       busy_res,
    output logic [COMP_W-1:0]          active_component,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    recipe_t           load_recipe;
    recipe_t           sel_recipe;
    logic [SLOT_W-1:0] sel_slot;
    result_t           result;
    result_t           out_data;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // Assemble the recipe being loaded
    always_comb
    begin
        load_recipe.gas_mask = gas_mask;
        load_recipe.dose[0]  = dose_one;
        load_recipe.dose[1]  = dose_two;
        load_recipe.dose[2]  = dose_three;
        load_recipe.dose[3]  = dose_four;
        load_recipe.dose[4]  = dose_five;
        load_recipe.dose[5]  = dose_six;
    end

    rds_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_idx  (cfg_index),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    rds_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_en     (accept && action),
        .load_recipe (load_recipe),
        .rd_slot     (sel_slot),
        .rd_recipe   (sel_recipe)
    );

    rds_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action),
        .button_down (button_down),
        .cfg         (cfg),
        .sel_recipe  (sel_recipe),
        .sel_slot    (sel_slot),
        .result      (result)
    );

    rds_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Unpack the result onto the output ports
    assign valve_mask       = out_data.valve_mask;
    assign pump_liquid      = out_data.pump_liquid;
    assign pump_gas         = out_data.pump_gas;
    assign bypass_valve     = out_data.bypass_valve;
    assign selected_slot    = out_data.selected_slot;
    assign busy_res         = out_data.busy_res;
    assign active_component = out_data.active_component;

endmodule

`default_nettype wire
